[rtl/pmd_pkg.sv]
`timescale 1ns / 1ps

package pmd_pkg;

    localparam int TABLE_ENTRIES_DEF = 44;
    localparam int MAX_SYMBOLS_DEF   = 6;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int ROM_SLOTS   = 64;
    localparam int CHAR_W      = 7;
    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;

    typedef enum logic [1:0] {
        SYM_LETTER_GAP = 2'b00,
        SYM_DASH       = 2'b01,
        SYM_DOT        = 2'b10,
        SYM_WORD_GAP   = 2'b11
    } sym_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [2:0]        len;
        logic [5:0]        pat;
    } rom_entry_t;

    // characters produced by one input byte, in symbol order
    typedef struct packed {
        logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                   last_idx;
    } burst_t;

    function automatic rom_entry_t ent(input logic [7:0] c, input logic [2:0] n,
                                       input logic [5:0] p);
        rom_entry_t e;
        e.ch  = c[CHAR_W-1:0];
        e.len = n;
        e.pat = p;
        return e;
    endfunction

    localparam rom_entry_t LETTER_ROM [ROM_SLOTS] = '{
        0:  ent("A", 3'd2, 6'h01),  1: ent("B", 3'd4, 6'h08),
        2:  ent("C", 3'd4, 6'h0A),  3: ent("D", 3'd3, 6'h04),
        4:  ent("E", 3'd1, 6'h00),  5: ent("F", 3'd4, 6'h02),
        6:  ent("G", 3'd3, 6'h06),  7: ent("H", 3'd4, 6'h00),
        8:  ent("I", 3'd2, 6'h00),  9: ent("J", 3'd4, 6'h07),
        10: ent("K", 3'd3, 6'h05), 11: ent("L", 3'd4, 6'h04),
        12: ent("M", 3'd2, 6'h03), 13: ent("N", 3'd2, 6'h02),
        14: ent("O", 3'd3, 6'h07), 15: ent("P", 3'd4, 6'h06),
        16: ent("Q", 3'd4, 6'h0D), 17: ent("R", 3'd3, 6'h02),
        18: ent("S", 3'd3, 6'h00), 19: ent("T", 3'd1, 6'h01),
        20: ent("U", 3'd3, 6'h01), 21: ent("V", 3'd4, 6'h01),
        22: ent("W", 3'd3, 6'h03), 23: ent("X", 3'd4, 6'h09),
        24: ent("Y", 3'd4, 6'h0B), 25: ent("Z", 3'd4, 6'h0C),
        26: ent("1", 3'd5, 6'h0F), 27: ent("2", 3'd5, 6'h07),
        28: ent("3", 3'd5, 6'h03), 29: ent("4", 3'd5, 6'h01),
        30: ent("5", 3'd5, 6'h00), 31: ent("6", 3'd5, 6'h10),
        32: ent("7", 3'd5, 6'h18), 33: ent("8", 3'd5, 6'h1C),
        34: ent("9", 3'd5, 6'h1E), 35: ent("0", 3'd5, 6'h1F),
        36: ent(",", 3'd6, 6'h33), 37: ent("?", 3'd6, 6'h0C),
        38: ent(".", 3'd6, 6'h15), 39: ent("!", 3'd5, 6'h06),
        40: ent(":", 3'd6, 6'h38), 41: ent(8'h27, 3'd6, 6'h1E),
        42: ent("=", 3'd5, 6'h11), 43: ent(8'h22, 3'd6, 6'h12),
        default: '0
    };

endpackage

[rtl/pmd_in_if.sv]
`timescale 1ns / 1ps

interface pmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       end_of_message;

    modport source (output valid, output packed_byte, output end_of_message, input ready);
    modport sink   (input valid, input packed_byte, input end_of_message, output ready);
endinterface

[rtl/pmd_out_if.sv]
`timescale 1ns / 1ps

interface pmd_out_if;
    logic                        valid;
    logic                        ready;
    logic [pmd_pkg::CHAR_W-1:0] character;
    logic                        last_of_run;

    modport source (output valid, output character, output last_of_run, input ready);
    modport sink   (input valid, input character, input last_of_run, output ready);
endinterface

[rtl/packed_morse_decoder_unit.sv]
`timescale 1ns / 1ps

// Packed Morse decoder. Each input transfer carries four 2-bit symbols (MSB pair
// first: 00 letter gap, 01 dash, 10 dot, 11 word gap) and an end-of-message flag
// that flushes the pending letter. A byte is decoded in the cycle it is accepted
// and its zero to four characters are queued as one entry; the output side sends
// one character per cycle while ready is high, flagging the last one of each byte
// with last_of_run. Input is taken every cycle while the queue has room, so a byte
// of n characters, at most four, is paced by the single character-wide output
// port. Characters reach the output through the queue registers. Bytes that yield
// nothing produce no output. No clearing pass at reset.
module packed_morse_decoder_unit #(
    parameter int TABLE_ENTRIES = pmd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_SYMBOLS   = pmd_pkg::MAX_SYMBOLS_DEF,
    parameter int QUEUE_DEPTH   = pmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pmd_in_if.sink    in_ch,
    pmd_out_if.source out_ch
);

    logic            push, pop, full, empty;
    pmd_pkg::burst_t push_data, head;

    pmd_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_SYMBOLS   (MAX_SYMBOLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    pmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    pmd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

[rtl/pmd_front.sv]
`timescale 1ns / 1ps

module pmd_front #(
    parameter int TABLE_ENTRIES = pmd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_SYMBOLS   = pmd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    pmd_in_if.sink          in_ch,
    input  logic            full,
    output logic            push,
    output pmd_pkg::burst_t push_data
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    logic [MAX_SYMBOLS-1:0] pat_reg, pat_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   spoiled_reg, spoiled_next;
    logic                   accept;
    logic [pmd_pkg::NUM_W-1:0] num;

    // {hit, character}; first matching slot wins
    function automatic logic [pmd_pkg::CHAR_W:0] lookup(input logic [MAX_SYMBOLS-1:0] pat,
                                                        input logic [CNT_W-1:0] cnt);
        logic                       hit;
        logic [pmd_pkg::CHAR_W-1:0] ch;
        pmd_pkg::rom_entry_t        e;
        hit = 1'b0;
        ch  = '0;
        for (int i = 0; i < pmd_pkg::ROM_SLOTS; i++)
        begin
            e = pmd_pkg::LETTER_ROM[i];
            if (i < TABLE_ENTRIES && !hit && e.len != 3'd0 && CNT_W'(e.len) == cnt
                && MAX_SYMBOLS'(e.pat) == pat)
            begin
                hit = 1'b1;
                ch  = e.ch;
            end
        end
        return {hit, ch};
    endfunction

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [MAX_SYMBOLS-1:0]     pat;
        logic [CNT_W-1:0]           cnt;
        logic                       spl;
        logic                       emit;
        logic [pmd_pkg::CHAR_W-1:0] ech;
        logic [pmd_pkg::CHAR_W:0]   lk;
        pmd_pkg::sym_t              sym;
        pat  = pat_reg;
        cnt  = cnt_reg;
        spl  = spoiled_reg;
        lk   = '0;
        num  = '0;
        push_data = '0;
        for (int k = 0; k < 4; k++)
        begin
            sym  = pmd_pkg::sym_t'(in_ch.packed_byte[7 - 2 * k -: 2]);
            emit = 1'b0;
            ech  = '0;
            unique case (sym) inside
                pmd_pkg::SYM_LETTER_GAP:
                begin
                    lk   = lookup(pat, cnt);
                    emit = lk[pmd_pkg::CHAR_W] && cnt != '0 && !spl;
                    ech  = lk[pmd_pkg::CHAR_W-1:0];
                    pat  = '0;
                    cnt  = '0;
                    spl  = 1'b0;
                end
                pmd_pkg::SYM_WORD_GAP:
                begin
                    if (cnt == '0 && !spl)
                    begin
                        emit = 1'b1;
                        ech  = pmd_pkg::SPACE_CHAR;
                    end
                    else
                    begin
                        spl = 1'b1;
                    end
                end
                pmd_pkg::SYM_DOT, pmd_pkg::SYM_DASH:
                begin
                    if (!spl)
                    begin
                        if (cnt >= CNT_W'(MAX_SYMBOLS))
                        begin
                            spl = 1'b1;
                        end
                        else
                        begin
                            pat = {pat[MAX_SYMBOLS-2:0], sym == pmd_pkg::SYM_DASH};
                            cnt = cnt + 1'b1;
                        end
                    end
                end
                default:
                begin
                    spl = spl;
                end
            endcase
            if (emit && num != pmd_pkg::NUM_W'(pmd_pkg::MAX_RESULTS))
            begin
                push_data.chars[num[pmd_pkg::IDX_W-1:0]] = ech;
                num = num + 1'b1;
            end
        end
        // end of message: flush as a trailing letter gap
        if (in_ch.end_of_message)
        begin
            lk = lookup(pat, cnt);
            if (lk[pmd_pkg::CHAR_W] && cnt != '0 && !spl
                && num != pmd_pkg::NUM_W'(pmd_pkg::MAX_RESULTS))
            begin
                push_data.chars[num[pmd_pkg::IDX_W-1:0]] = lk[pmd_pkg::CHAR_W-1:0];
                num = num + 1'b1;
            end
            pat = '0;
            cnt = '0;
            spl = 1'b0;
        end
        push_data.last_idx = pmd_pkg::IDX_W'(num - 1'b1);
        pat_next     = pat;
        cnt_next     = cnt;
        spoiled_next = spl;
    end

    assign push = accept && num != '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg     <= '0;
            cnt_reg     <= '0;
            spoiled_reg <= 1'b0;
        end
        else if (accept)
        begin
            pat_reg     <= pat_next;
            cnt_reg     <= cnt_next;
            spoiled_reg <= spoiled_next;
        end
    end

endmodule

[rtl/pmd_queue.sv]
`timescale 1ns / 1ps

module pmd_queue #(
    parameter int DEPTH = pmd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pmd_pkg::burst_t push_data,
    input  logic            pop,
    output pmd_pkg::burst_t head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmd_pkg::burst_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    assign full  = fill_reg == CNT_W'(DEPTH);
    assign empty = fill_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/pmd_back.sv]
`timescale 1ns / 1ps

module pmd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  pmd_pkg::burst_t head,
    input  logic            empty,
    output logic            pop,
    pmd_out_if.source       out_ch
);

    logic [pmd_pkg::IDX_W-1:0] idx_reg;
    logic                      last;
    logic                      xfer;

    assign last               = idx_reg == head.last_idx;
    assign out_ch.valid       = !empty;
    assign out_ch.character   = head.chars[idx_reg];
    assign out_ch.last_of_run = last;
    assign xfer               = out_ch.valid && out_ch.ready;
    assign pop                = xfer && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (xfer)
        begin
            idx_reg <= last ? '0 : idx_reg + 1'b1;
        end
    end

endmodule

[rtl/pmd_checker.sv]
`timescale 1ns / 1ps

module pmd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [pmd_pkg::CHAR_W-1:0] character,
    input logic                       last_of_run
);

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last_of_run))
        else $error("output changed while stalled");

    // input backpressure only when something is queued for output
    a_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with nothing to send");

    // every character lies between space and Z, a range that holds all table characters
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> character >= pmd_pkg::SPACE_CHAR && character <= 7'h5A)
        else $error("character outside decoded set");

    // no output right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind packed_morse_decoder_unit pmd_checker u_pmd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .character   (out_ch.character),
    .last_of_run (out_ch.last_of_run)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 250;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int LETTER_COUNT  = 44;

    typedef struct packed {
        logic [pmd_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } char_t;

    // Decoder predictor and queue of characters still owed by the block.
    class morse_scoreboard;
        string       code[LETTER_COUNT];
        logic [5:0]  letter_pattern;
        int unsigned letter_len;
        bit          letter_spoiled;
        char_t       expected_chars[$];
        int          errors;
        int          bytes_seen;
        int          flushes;
        int          chars_checked;
        int          spaces_checked;

        function new();
            // first character is the symbol, the rest is its dot/dash spelling
            code = '{"A.-", "B-...", "C-.-.", "D-..", "E.", "F..-.", "G--.", "H....",
                     "I..", "J.---", "K-.-", "L.-..", "M--", "N-.", "O---", "P.--.",
                     "Q--.-", "R.-.", "S...", "T-", "U..-", "V...-", "W.--", "X-..-",
                     "Y-.--", "Z--..", "1.----", "2..---", "3...--", "4....-",
                     "5.....", "6-....", "7--...", "8---..", "9----.", "0-----",
                     ",--..--", "?..--..", "..-.-.-", "!..--.", ":---...",
                     "'.----.", "=-...-", "\".-..-."};
            letter_pattern = '0;
            letter_len     = 0;
            letter_spoiled = 1'b0;
            errors         = 0;
            bytes_seen     = 0;
            flushes        = 0;
            chars_checked  = 0;
            spaces_checked = 0;
        endfunction

        function int finish_letter();
            int         found;
            int         n;
            logic [5:0] p;
            found = -1;
            if (letter_len != 0 && !letter_spoiled)
                foreach (code[i])
                begin
                    if (found < 0 && code[i].len() - 1 == letter_len)
                    begin
                        p = '0;
                        for (n = 1; n < code[i].len(); n++)
                            p = {p[4:0], code[i][n] == "-"};
                        if (p == letter_pattern)
                            found = code[i][0];
                    end
                end
            letter_pattern = '0;
            letter_len     = 0;
            letter_spoiled = 1'b0;
            return found;
        endfunction

        function void note_byte(logic [7:0] b, bit eom);
            char_t         got[$];
            char_t         item;
            pmd_pkg::sym_t sym;
            int            ch;
            bytes_seen++;
            if (eom)
                flushes++;
            for (int k = 0; k < 4; k++)
            begin
                sym = pmd_pkg::sym_t'(b[7 - 2 * k -: 2]);
                ch  = -1;
                case (sym)
                    pmd_pkg::SYM_LETTER_GAP: ch = finish_letter();
                    pmd_pkg::SYM_WORD_GAP:
                        if (letter_len == 0 && !letter_spoiled)
                            ch = int'(pmd_pkg::SPACE_CHAR);
                        else
                            letter_spoiled = 1'b1;
                    default:
                        if (!letter_spoiled)
                        begin
                            if (letter_len >= pmd_pkg::MAX_SYMBOLS_DEF)
                                letter_spoiled = 1'b1;
                            else
                            begin
                                letter_pattern = {letter_pattern[4:0],
                                                  sym == pmd_pkg::SYM_DASH};
                                letter_len++;
                            end
                        end
                endcase
                if (ch >= 0 && got.size() < pmd_pkg::MAX_RESULTS)
                begin
                    item.ch   = ch[pmd_pkg::CHAR_W-1:0];
                    item.last = 1'b0;
                    got = {got, item};
                end
            end
            if (eom)
            begin
                ch = finish_letter();
                if (ch >= 0 && got.size() < pmd_pkg::MAX_RESULTS)
                begin
                    item.ch   = ch[pmd_pkg::CHAR_W-1:0];
                    item.last = 1'b0;
                    got = {got, item};
                end
            end
            if (got.size() > 0)
                got[got.size() - 1].last = 1'b1;
            foreach (got[i])
                expected_chars = {expected_chars, got[i]};
        endfunction

        function void check_char(logic [pmd_pkg::CHAR_W-1:0] ch, logic last);
            char_t want;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character 0x%02h, last_of_run %0b", ch, last);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            chars_checked++;
            if (want.ch == pmd_pkg::SPACE_CHAR)
                spaces_checked++;
            if (ch !== want.ch)
            begin
                $error("character: expected 0x%02h, got 0x%02h", want.ch, ch);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_of_run: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pmd_in_if  in_ch();
    pmd_out_if out_ch();

    packed_morse_decoder_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    morse_scoreboard sb = new();
    int burst_left = 0;

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [7:0] pack4(pmd_pkg::sym_t a, pmd_pkg::sym_t b,
                                         pmd_pkg::sym_t c, pmd_pkg::sym_t d);
        return {a, b, c, d};
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit eom);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid          <= 1'b1;
        in_ch.packed_byte    <= b;
        in_ch.end_of_message <= eom;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_byte(b, eom);
    endtask

    // receiver: random short stalls, with calm stretches of steady ready
    initial
    begin
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_char(out_ch.character, out_ch.last_of_run);
            if (calm > 0)
                calm--;
            else if ($urandom_range(0, 150) == 0)
                calm = $urandom_range(20, 80);
            if (stall > 0)
                stall--;
            else if (calm == 0 && $urandom_range(0, 3) == 0)
                stall = $urandom_range(1, 7);
            out_ch.ready <= (stall == 0);
        end
    end

    // watchdog: too long without any transfer on either side
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $error("no transfer for %0d cycles", IDLE_LIMIT);
        $display("packed_morse_decoder_unit regression: fail");
        $finish;
    end

    initial
    begin
        pmd_pkg::sym_t sym_q[$];
        string         s;
        int            r;
        int            n;
        logic [7:0]    b;
        bit            eom;

        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.packed_byte    <= '0;
        in_ch.end_of_message <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_DASH, pmd_pkg::SYM_LETTER_GAP,
                        pmd_pkg::SYM_WORD_GAP), 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_WORD_GAP, pmd_pkg::SYM_LETTER_GAP,
                        pmd_pkg::SYM_LETTER_GAP), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DASH, pmd_pkg::SYM_DASH, pmd_pkg::SYM_DOT,
                        pmd_pkg::SYM_DOT), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DASH, pmd_pkg::SYM_DASH, pmd_pkg::SYM_LETTER_GAP,
                        pmd_pkg::SYM_WORD_GAP), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT,
                        pmd_pkg::SYM_DOT), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT,
                        pmd_pkg::SYM_LETTER_GAP), 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(pack4(pmd_pkg::SYM_DASH, pmd_pkg::SYM_WORD_GAP, pmd_pkg::SYM_DASH,
                        pmd_pkg::SYM_DOT), 1'b1);
        send_byte(pack4(pmd_pkg::SYM_WORD_GAP, pmd_pkg::SYM_DASH, pmd_pkg::SYM_DASH,
                        pmd_pkg::SYM_DASH), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_LETTER_GAP, pmd_pkg::SYM_WORD_GAP,
                        pmd_pkg::SYM_WORD_GAP, pmd_pkg::SYM_DOT), 1'b1);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_DASH, pmd_pkg::SYM_DOT,
                        pmd_pkg::SYM_DASH), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_DASH, pmd_pkg::SYM_LETTER_GAP,
                        pmd_pkg::SYM_LETTER_GAP), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_LETTER_GAP, pmd_pkg::SYM_DASH,
                        pmd_pkg::SYM_LETTER_GAP), 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT,
                        pmd_pkg::SYM_DOT), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT, pmd_pkg::SYM_LETTER_GAP,
                        pmd_pkg::SYM_LETTER_GAP), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DASH, pmd_pkg::SYM_DOT, pmd_pkg::SYM_DOT,
                        pmd_pkg::SYM_DOT), 1'b0);
        send_byte(pack4(pmd_pkg::SYM_DOT, pmd_pkg::SYM_LETTER_GAP, pmd_pkg::SYM_WORD_GAP,
                        pmd_pkg::SYM_LETTER_GAP), 1'b0);

        // random: mostly real letters, some overlong or broken ones, some raw bytes
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                b   = 8'($urandom_range(0, 255));
                eom = 1'($urandom_range(0, 1));
            end
            else
            begin
                while (sym_q.size() < 4)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                    begin
                        s = sb.code[$urandom_range(0, LETTER_COUNT - 1)];
                        for (n = 1; n < s.len(); n++)
                            sym_q = {sym_q,
                                     (s[n] == "-") ? pmd_pkg::SYM_DASH : pmd_pkg::SYM_DOT};
                        sym_q = {sym_q, pmd_pkg::SYM_LETTER_GAP};
                        if ($urandom_range(0, 3) == 0)
                            sym_q = {sym_q, pmd_pkg::SYM_WORD_GAP};
                    end
                    else if (r < 80)
                    begin
                        repeat ($urandom_range(1, 3)) sym_q = {sym_q, pmd_pkg::SYM_WORD_GAP};
                    end
                    else if (r < 90)
                    begin
                        repeat ($urandom_range(7, 9))
                            sym_q = {sym_q, ($urandom_range(0, 1) != 0) ?
                                            pmd_pkg::SYM_DASH : pmd_pkg::SYM_DOT};
                        sym_q = {sym_q, pmd_pkg::SYM_LETTER_GAP};
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 4))
                            sym_q = {sym_q, ($urandom_range(0, 1) != 0) ?
                                            pmd_pkg::SYM_DASH : pmd_pkg::SYM_DOT};
                        sym_q = {sym_q, pmd_pkg::SYM_WORD_GAP};
                        sym_q = {sym_q, pmd_pkg::SYM_LETTER_GAP};
                    end
                end
                b = '0;
                repeat (4) b = {b[5:0], sym_q.pop_front()};
                eom = ($urandom_range(0, 9) == 0);
            end
            send_byte(b, eom);
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("decoded %0d bytes (%0d with end of message), directed and random",
                 sb.bytes_seen, sb.flushes);
        $display("checked %0d characters, %0d of them spaces, under random stalls",
                 sb.chars_checked, sb.spaces_checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("packed_morse_decoder_unit regression: pass");
        else
            $display("packed_morse_decoder_unit regression: fail");
        $finish;
    end

endmodule
